FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Widths, microcode word layout and the microprogram of the particle stepper.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int DAMP_W    = 17;
    localparam int OPA_W     = DATA_W + 1;
    localparam int OPB_W     = 26;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int UPC_W     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 3'd4;

    localparam logic signed [DATA_W-1:0] ACCEL_Y_RESET = -32'sd642908;
    localparam logic [DAMP_W-1:0]        DAMPING_RESET = 17'd52429;

    typedef enum logic [2:0] {
        A_AX, A_AY, A_AZ, A_VX, A_VY, A_VZ, A_NVY
    } a_sel_t;

    typedef enum logic [1:0] {
        B_DT, B_DAMP, B_NINE
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_ADD, ACC_SCALE, ACC_BOUNCE
    } acc_t;

    typedef enum logic [2:0] {
        D_VX, D_VY, D_VZ, D_PX, D_PY, D_PZ
    } dst_t;

    typedef enum logic [2:0] {
        FL_NEXT, FL_JUMP, FL_JNG, FL_JNF, FL_DONE
    } flow_t;

    typedef struct packed {
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        acc_t             acc;
        dst_t             dst;
        logic             floor_chk;
        logic             wall;
        logic             load_vel;
        flow_t            flow;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic gravity;
        logic floor;
    } pes_stat_t;

    localparam logic [UPC_W-1:0] ENTRY_STEP = 4'd0;
    localparam logic [UPC_W-1:0] ENTRY_LOAD = 4'd13;

    function automatic uword_t uw(input a_sel_t a, input b_sel_t b, input acc_t acc,
                                  input dst_t dst, input logic fl, input logic wl,
                                  input logic ld, input flow_t flow,
                                  input logic [UPC_W-1:0] tgt);
        uword_t w;
        w.a_sel     = a;
        w.b_sel     = b;
        w.acc       = acc;
        w.dst       = dst;
        w.floor_chk = fl;
        w.wall      = wl;
        w.load_vel  = ld;
        w.flow      = flow;
        w.target    = tgt;
        return w;
    endfunction

    // Each word multiplies into the product register and, in the same cycle,
    // retires the product of the previous word into its destination.
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            4'd0:  w = uw(A_AX,  B_DT,   ACC_NONE,   D_VX, 1'b0, 1'b0, 1'b0, FL_JNG,  4'd4);
            4'd1:  w = uw(A_AY,  B_DT,   ACC_ADD,    D_VX, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd2:  w = uw(A_AZ,  B_DT,   ACC_ADD,    D_VY, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd3:  w = uw(A_VX,  B_DT,   ACC_ADD,    D_VZ, 1'b0, 1'b0, 1'b0, FL_JUMP, 4'd5);
            4'd4:  w = uw(A_VX,  B_DT,   ACC_NONE,   D_VX, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd5:  w = uw(A_VY,  B_DT,   ACC_ADD,    D_PX, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd6:  w = uw(A_VZ,  B_DT,   ACC_ADD,    D_PY, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd7:  w = uw(A_NVY, B_DAMP, ACC_ADD,    D_PZ, 1'b1, 1'b0, 1'b0, FL_JNF,  4'd11);
            4'd8:  w = uw(A_VX,  B_NINE, ACC_BOUNCE, D_VY, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd9:  w = uw(A_VZ,  B_NINE, ACC_SCALE,  D_VX, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd10: w = uw(A_VX,  B_DT,   ACC_SCALE,  D_VZ, 1'b0, 1'b0, 1'b0, FL_NEXT, 4'd0);
            4'd11: w = uw(A_VX,  B_DT,   ACC_NONE,   D_VX, 1'b0, 1'b1, 1'b0, FL_NEXT, 4'd0);
            4'd12: w = uw(A_VX,  B_DT,   ACC_NONE,   D_VX, 1'b0, 1'b0, 1'b0, FL_DONE, 4'd0);
            4'd13: w = uw(A_VX,  B_DT,   ACC_NONE,   D_VX, 1'b0, 1'b0, 1'b1, FL_JUMP, 4'd12);
            default: w = uw(A_VX, B_DT,  ACC_NONE,   D_VX, 1'b0, 1'b0, 1'b0, FL_DONE, 4'd0);
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/pes_seq.sv
// ----------------------------------------------------------------------------
// pes_seq
// Microprogram sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module pes_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              load_op,
    input  pes_pkg::pes_stat_t stat,
    input  logic              out_blocked,
    output pes_pkg::uword_t   ctl,
    output logic              exec,
    output logic              busy,
    output logic              done
);
    import pes_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_inc;

    assign ctl     = ucode(upc_reg);
    assign upc_inc = upc_reg + 1'b1;
    assign exec    = busy_reg;
    assign busy    = busy_reg;
    assign done    = busy_reg && (ctl.flow == FL_DONE) && !out_blocked;

    always_comb begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (start) begin
            upc_next  = load_op ? ENTRY_LOAD : ENTRY_STEP;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            unique case (ctl.flow)
                FL_NEXT: upc_next = upc_inc;
                FL_JUMP: upc_next = ctl.target;
                FL_JNG:  upc_next = stat.gravity ? upc_inc : ctl.target;
                FL_JNF:  upc_next = stat.floor ? upc_inc : ctl.target;
                FL_DONE: busy_next = !done;
                default: upc_next = upc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            upc_reg  <= ENTRY_STEP;
            busy_reg <= 1'b0;
        end else begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: hw/rtl/pes_dp.sv
// ----------------------------------------------------------------------------
// pes_dp
// Datapath: velocity state, working position, one shared multiplier with a
// product register, saturating accumulate, floor and wall rules.
// ----------------------------------------------------------------------------
module pes_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   exec,
    input  pes_pkg::uword_t                        ctl,
    input  logic                                   gravity_enable,
    input  logic signed [pes_pkg::DATA_W-1:0]      accel_x,
    input  logic signed [pes_pkg::DATA_W-1:0]      accel_y,
    input  logic signed [pes_pkg::DATA_W-1:0]      accel_z,
    input  logic [pes_pkg::DAMP_W-1:0]             bounce_damping,
    input  logic [pes_pkg::DT_W-1:0]               delta_time,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_x,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_y,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_z,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_x,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_y,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_z,
    output logic signed [pes_pkg::DATA_W-1:0]      px,
    output logic signed [pes_pkg::DATA_W-1:0]      py,
    output logic signed [pes_pkg::DATA_W-1:0]      pz,
    output logic signed [pes_pkg::DATA_W-1:0]      vx,
    output logic signed [pes_pkg::DATA_W-1:0]      vy,
    output logic signed [pes_pkg::DATA_W-1:0]      vz,
    output logic                                   hit,
    output pes_pkg::pes_stat_t                     stat
);
    import pes_pkg::*;

    localparam logic signed [DATA_W-1:0] HALF_FX  = DATA_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [DATA_W-1:0] TEN_FX   = DATA_W'(10 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] TENTH_FX = DATA_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [OPB_W-1:0]  NINE_FX  = OPB_W'(((9 << FRAC_BITS) + 5) / 10);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] top;
        top = v[PROD_W-1:DATA_W-1];
        if (&top || ~|top) begin
            return v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // floor(-v / 2), computed one bit wider so the most negative value works.
    function automatic logic signed [DATA_W-1:0] half_neg(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] n;
        n = -{v[DATA_W-1], v};
        return DATA_W'(n >>> 1);
    endfunction

    logic signed [DATA_W-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [DATA_W-1:0] vx_next, vy_next, vz_next;
    logic signed [DATA_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [DATA_W-1:0] px_next, py_next, pz_next;
    logic signed [DATA_W-1:0] setv_x_reg, setv_y_reg, setv_z_reg;
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic                     hit_reg, hit_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] sh16;
    logic signed [PROD_W-1:0] shf;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [DATA_W-1:0] dst_cur;
    logic signed [DATA_W-1:0] bounce;
    logic signed [DATA_W-1:0] acc_val;
    logic                     floor_cond;
    logic                     x_out, z_out;

    always_comb begin
        unique case (ctl.a_sel)
            A_AX:    opa = {accel_x[DATA_W-1], accel_x};
            A_AY:    opa = {accel_y[DATA_W-1], accel_y};
            A_AZ:    opa = {accel_z[DATA_W-1], accel_z};
            A_VX:    opa = {vx_reg[DATA_W-1], vx_reg};
            A_VY:    opa = {vy_reg[DATA_W-1], vy_reg};
            A_VZ:    opa = {vz_reg[DATA_W-1], vz_reg};
            A_NVY:   opa = -{vy_reg[DATA_W-1], vy_reg};
            default: opa = '0;
        endcase
    end

    always_comb begin
        unique case (ctl.b_sel)
            B_DT:    opb = {{(OPB_W-DT_W){1'b0}}, dt_reg};
            B_DAMP:  opb = {{(OPB_W-DAMP_W){1'b0}}, bounce_damping};
            B_NINE:  opb = NINE_FX;
            default: opb = '0;
        endcase
    end

    assign prod_next = opa * opb;
    assign sh16      = prod_reg >>> DT_W;
    assign shf       = prod_reg >>> FRAC_BITS;

    always_comb begin
        unique case (ctl.dst)
            D_VX:    dst_cur = vx_reg;
            D_VY:    dst_cur = vy_reg;
            D_VZ:    dst_cur = vz_reg;
            D_PX:    dst_cur = px_reg;
            D_PY:    dst_cur = py_reg;
            D_PZ:    dst_cur = pz_reg;
            default: dst_cur = '0;
        endcase
    end

    assign acc_sum = PROD_W'(dst_cur) + sh16;
    assign bounce  = sat32(sh16);

    always_comb begin
        unique case (ctl.acc)
            ACC_ADD:    acc_val = sat32(acc_sum);
            ACC_SCALE:  acc_val = sat32(shf);
            // A rebound slower than a tenth comes to rest.
            ACC_BOUNCE: acc_val = ((bounce < TENTH_FX) && (bounce > -TENTH_FX)) ? '0 : bounce;
            default:    acc_val = '0;
        endcase
    end

    assign floor_cond = (py_reg < HALF_FX) && vy_reg[DATA_W-1];
    assign x_out      = (px_reg > TEN_FX) || (px_reg < -TEN_FX);
    assign z_out      = (pz_reg > TEN_FX) || (pz_reg < -TEN_FX);

    always_comb begin
        vx_next  = vx_reg;
        vy_next  = vy_reg;
        vz_next  = vz_reg;
        px_next  = px_reg;
        py_next  = py_reg;
        pz_next  = pz_reg;
        dt_next  = dt_reg;
        hit_next = hit_reg;
        if (start) begin
            px_next  = pos_x;
            py_next  = pos_y;
            pz_next  = pos_z;
            dt_next  = delta_time;
            hit_next = 1'b0;
        end else if (exec) begin
            if (ctl.acc != ACC_NONE) begin
                unique case (ctl.dst)
                    D_VX:    vx_next = acc_val;
                    D_VY:    vy_next = acc_val;
                    D_VZ:    vz_next = acc_val;
                    D_PX:    px_next = acc_val;
                    D_PY:    py_next = acc_val;
                    D_PZ:    pz_next = acc_val;
                    default: px_next = px_reg;
                endcase
            end
            if (ctl.floor_chk && floor_cond) begin
                py_next  = HALF_FX;
                hit_next = 1'b1;
            end
            if (ctl.wall) begin
                if (x_out) begin
                    vx_next = half_neg(vx_reg);
                    px_next = px_reg[DATA_W-1] ? -TEN_FX : TEN_FX;
                end
                if (z_out) begin
                    vz_next = half_neg(vz_reg);
                    pz_next = pz_reg[DATA_W-1] ? -TEN_FX : TEN_FX;
                end
            end
            if (ctl.load_vel) begin
                vx_next = setv_x_reg;
                vy_next = setv_y_reg;
                vz_next = setv_z_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vx_reg  <= '0;
            vy_reg  <= '0;
            vz_reg  <= '0;
            hit_reg <= 1'b0;
        end else begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            vz_reg  <= vz_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        dt_reg   <= dt_next;
        prod_reg <= prod_next;
    end

    // The velocity to load is held from the transfer, since the input port
    // may already carry the next item when the load word runs.
    always_ff @(posedge clk) begin
        if (start) begin
            setv_x_reg <= set_vel_x;
            setv_y_reg <= set_vel_y;
            setv_z_reg <= set_vel_z;
        end
    end

    assign px           = px_reg;
    assign py           = py_reg;
    assign pz           = pz_reg;
    assign vx           = vx_reg;
    assign vy           = vy_reg;
    assign vz           = vz_reg;
    assign hit          = hit_reg;
    assign stat.gravity = gravity_enable;
    assign stat.floor   = floor_cond;

endmodule

FILE: hw/rtl/particle_euler_step_with_bounce_top.sv
// ----------------------------------------------------------------------------
// particle_euler_step_with_bounce_top
// Semi-implicit Euler step of one body in signed fixed point, with a floor
// bounce and side walls at plus and minus ten.
// ----------------------------------------------------------------------------
// One item is worked at a time. From its transfer, a step item keeps the
// sequencer busy longest with gravity and a floor bounce and shortest with
// neither; a velocity load is shorter still. The busy time is set by the
// microprogram driving one shared 33x26 multiplier, one multiply per cycle,
// with each product retired into its destination by the following word. The
// result goes into an output register, and the next item is taken in the
// cycle after the result is written there, even while that result is still
// stalled. Configuration writes are taken at any time but belong in idle
// periods.
`include "assert_macros.svh"

module particle_euler_step_with_bounce_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic [pes_pkg::DT_W-1:0]               delta_time,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_x,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_y,
    input  logic signed [pes_pkg::DATA_W-1:0]      pos_z,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_x,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_y,
    input  logic signed [pes_pkg::DATA_W-1:0]      set_vel_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pes_pkg::DATA_W-1:0]      new_pos_x,
    output logic signed [pes_pkg::DATA_W-1:0]      new_pos_y,
    output logic signed [pes_pkg::DATA_W-1:0]      new_pos_z,
    output logic signed [pes_pkg::DATA_W-1:0]      new_vel_x,
    output logic signed [pes_pkg::DATA_W-1:0]      new_vel_y,
    output logic signed [pes_pkg::DATA_W-1:0]      new_vel_z,
    output logic                                   floor_hit,
    input  logic                                   cfg_write,
    input  logic [pes_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pes_pkg::DATA_W-1:0]             cfg_data
);
    import pes_pkg::*;

    localparam logic signed [DATA_W-1:0] HALF_FX = DATA_W'(1 << (FRAC_BITS - 1));

    logic                     gravity_reg;
    logic signed [DATA_W-1:0] accel_x_reg, accel_y_reg, accel_z_reg;
    logic [DAMP_W-1:0]        damping_reg;

    logic                     start;
    logic                     seq_exec;
    logic                     seq_busy;
    logic                     seq_done;
    uword_t                   ctl;
    pes_stat_t                stat;

    logic signed [DATA_W-1:0] dp_px, dp_py, dp_pz, dp_vx, dp_vy, dp_vz;
    logic                     dp_hit;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [DATA_W-1:0] vel_x_reg, vel_y_reg, vel_z_reg;
    logic                     hit_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gravity_reg <= 1'b1;
            accel_x_reg <= '0;
            accel_y_reg <= ACCEL_Y_RESET;
            accel_z_reg <= '0;
            damping_reg <= DAMPING_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_GRAVITY: gravity_reg <= cfg_data[0];
                REG_ACCEL_X: accel_x_reg <= cfg_data;
                REG_ACCEL_Y: accel_y_reg <= cfg_data;
                REG_ACCEL_Z: accel_z_reg <= cfg_data;
                REG_DAMPING: damping_reg <= cfg_data[DAMP_W-1:0];
                default:     gravity_reg <= gravity_reg;
            endcase
        end
    end

    assign start    = in_valid && !seq_busy;
    assign in_stall = seq_busy;

    pes_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .load_op     (operation),
        .stat        (stat),
        .out_blocked (out_valid_reg && out_stall),
        .ctl         (ctl),
        .exec        (seq_exec),
        .busy        (seq_busy),
        .done        (seq_done)
    );

    pes_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .exec           (seq_exec),
        .ctl            (ctl),
        .gravity_enable (gravity_reg),
        .accel_x        (accel_x_reg),
        .accel_y        (accel_y_reg),
        .accel_z        (accel_z_reg),
        .bounce_damping (damping_reg),
        .delta_time     (delta_time),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .set_vel_x      (set_vel_x),
        .set_vel_y      (set_vel_y),
        .set_vel_z      (set_vel_z),
        .px             (dp_px),
        .py             (dp_py),
        .pz             (dp_pz),
        .vx             (dp_vx),
        .vy             (dp_vy),
        .vz             (dp_vz),
        .hit            (dp_hit),
        .stat           (stat)
    );

    // The sequencer holds at its final word until the output register is free.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (seq_done) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (seq_done) begin
            pos_x_reg <= dp_px;
            pos_y_reg <= dp_py;
            pos_z_reg <= dp_pz;
            vel_x_reg <= dp_vx;
            vel_y_reg <= dp_vy;
            vel_z_reg <= dp_vz;
            hit_reg   <= dp_hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = pos_x_reg;
    assign new_pos_y = pos_y_reg;
    assign new_pos_z = pos_z_reg;
    assign new_vel_x = vel_x_reg;
    assign new_vel_y = vel_y_reg;
    assign new_vel_z = vel_z_reg;
    assign floor_hit = hit_reg;

    `ASSERT_NEXT(a_accept_starts_seq, clk, rst_n, in_valid && !in_stall, seq_busy)
    `ASSERT_NEXT(a_done_loads_output, clk, rst_n, seq_done, out_valid)
    `ASSERT_IMPLIES(a_hit_rests_on_floor, clk, rst_n, out_valid && floor_hit, new_pos_y == HALF_FX)

endmodule
